### rtl/rof_pkg.sv
// Shared types and constants of the offset/value packet filter.
`default_nettype none

package rof_pkg;

  localparam int unsigned VALUE_W     = 64;
  localparam int unsigned OFFSET_W    = 6;
  localparam int unsigned LENGTH_W    = 4;
  localparam int unsigned INDEX_W     = 4;
  localparam int unsigned FAILED_W    = 4;
  // Wide enough for a fill count of the largest window (64 bytes).
  localparam int unsigned FILL_W      = 7;
  localparam int unsigned FIELD_BYTES = 8;

  typedef enum logic {
    CMD_RULE = 1'b0,
    CMD_BYTE = 1'b1
  } cmd_e;

  typedef struct packed {
    logic [VALUE_W-1:0]  value;
    logic [OFFSET_W-1:0] offset;
    logic [LENGTH_W-1:0] length;
  } rule_t;

  typedef struct packed {
    logic              start;
    logic [FILL_W-1:0] fill;
  } job_t;

  typedef struct packed {
    logic                accept;
    logic [FAILED_W-1:0] failed_rule;
  } verdict_t;

  // Mask that keeps the low len bytes of a value; len is at most FIELD_BYTES.
  function automatic logic [VALUE_W-1:0] field_mask(logic [LENGTH_W-1:0] len);
    logic [VALUE_W-1:0] m;
    if (len >= LENGTH_W'(FIELD_BYTES)) begin
      m = '1;
    end else begin
      m = ~({VALUE_W{1'b1}} << {len[2:0], 3'b000});
    end
    return m;
  endfunction

endpackage

`default_nettype wire

### rtl/rof_front.sv
// Intake side: rule table, packet capture window and hand-off of finished packets.
`default_nettype none

module rof_front #(
  parameter int unsigned WINDOW_BYTES = 56,
  parameter int unsigned MAX_RULES    = 10,
  localparam int unsigned AW  = $clog2(WINDOW_BYTES),
  localparam int unsigned RIW = (MAX_RULES > 1) ? $clog2(MAX_RULES) : 1
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              in_valid_i,
  output logic                                   in_stall_o,
  input  wire logic                              cmd_i,
  input  wire logic [rof_pkg::INDEX_W-1:0]       rule_index_i,
  input  wire logic [rof_pkg::OFFSET_W-1:0]      rule_offset_i,
  input  wire logic [rof_pkg::LENGTH_W-1:0]      rule_length_i,
  input  wire logic [rof_pkg::VALUE_W-1:0]       rule_value_i,
  input  wire logic [7:0]                        data_byte_i,
  input  wire logic                              last_byte_i,
  output rof_pkg::job_t                          job_o,
  input  wire logic                              done_i,
  input  wire logic [RIW-1:0]                    rule_idx_i,
  output rof_pkg::rule_t                         rule_o,
  input  wire logic [AW-1:0]                     rd_addr_i,
  output logic [7:0]                             rd_data_o
);

  localparam int unsigned CW = $clog2(WINDOW_BYTES + 1);

  rof_pkg::rule_t              rules_q [MAX_RULES];
  logic [7:0]                  win_mem [WINDOW_BYTES];
  logic [7:0]                  rd_data_q;
  logic [CW-1:0]               pos_q, pos_d;
  logic                        busy_q, busy_d;
  rof_pkg::job_t               job_q, job_d;
  logic                        accept;
  logic                        byte_acc;
  logic                        rule_acc;
  logic                        wr_en;
  logic [RIW+rof_pkg::INDEX_W-1:0] idx_ext;
  logic                        idx_ok;
  logic [CW-1:0]               pos_next;

  assign accept   = in_valid_i & ~busy_q;
  assign byte_acc = accept & (cmd_i == rof_pkg::CMD_BYTE);
  assign rule_acc = accept & (cmd_i == rof_pkg::CMD_RULE);
  assign wr_en    = byte_acc & (pos_q < CW'(WINDOW_BYTES));
  assign pos_next = wr_en ? pos_q + CW'(1) : pos_q;

  assign idx_ext = {{RIW{1'b0}}, rule_index_i};
  assign idx_ok  = idx_ext < (RIW + rof_pkg::INDEX_W)'(MAX_RULES);

  always_comb begin
    pos_d  = pos_next;
    busy_d = busy_q;
    job_d  = '0;
    if (byte_acc && last_byte_i) begin
      // The window keeps the old bytes; the fill count masks them off.
      job_d.start = 1'b1;
      job_d.fill  = rof_pkg::FILL_W'(pos_next);
      pos_d       = '0;
      busy_d      = 1'b1;
    end else if (done_i) begin
      busy_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= '0;
      busy_q <= 1'b0;
      job_q  <= '0;
      for (int i = 0; i < int'(MAX_RULES); i++) begin
        rules_q[i] <= '0;
      end
    end else begin
      pos_q  <= pos_d;
      busy_q <= busy_d;
      job_q  <= job_d;
      if (rule_acc && idx_ok) begin
        rules_q[idx_ext[RIW-1:0]] <= '{value:  rule_value_i,
                                       offset: rule_offset_i,
                                       length: rule_length_i};
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      win_mem[pos_q[AW-1:0]] <= data_byte_i;
    end
    rd_data_q <= win_mem[rd_addr_i];
  end

  assign in_stall_o = busy_q;
  assign job_o      = job_q;
  assign rule_o     = rules_q[rule_idx_i];
  assign rd_data_o  = rd_data_q;

endmodule

`default_nettype wire

### rtl/rof_back.sv
// Rule walker: compares each active rule with the captured window, byte by byte.
`default_nettype none

module rof_back #(
  parameter int unsigned WINDOW_BYTES = 56,
  parameter int unsigned MAX_RULES    = 10,
  localparam int unsigned AW  = $clog2(WINDOW_BYTES),
  localparam int unsigned RIW = (MAX_RULES > 1) ? $clog2(MAX_RULES) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire rof_pkg::job_t    job_i,
  output logic                  done_o,
  output logic [RIW-1:0]        rule_idx_o,
  input  wire rof_pkg::rule_t   rule_i,
  output logic [AW-1:0]         rd_addr_o,
  input  wire logic [7:0]       rd_data_i,
  output logic                  push_o,
  output rof_pkg::verdict_t     verdict_o,
  input  wire logic             full_i
);

  localparam int unsigned RW = $clog2(MAX_RULES + 1);

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_RULE  = 6'b000010,
    ST_READ  = 6'b000100,
    ST_DATA  = 6'b001000,
    ST_CHECK = 6'b010000,
    ST_DONE  = 6'b100000
  } state_e;

  state_e                          state_q, state_d;
  logic [RW-1:0]                   r_q, r_d;
  logic [rof_pkg::FILL_W-1:0]      fill_q, fill_d;
  logic [rof_pkg::OFFSET_W-1:0]    off_q, off_d;
  logic [rof_pkg::LENGTH_W-1:0]    len_q, len_d;
  logic [rof_pkg::LENGTH_W-1:0]    k_q, k_d;
  logic [rof_pkg::VALUE_W-1:0]     want_q, want_d;
  logic [rof_pkg::VALUE_W-1:0]     seen_q, seen_d;
  logic [rof_pkg::FILL_W-1:0]      addr_q, addr_d;
  rof_pkg::verdict_t               verdict_q, verdict_d;

  logic [rof_pkg::LENGTH_W-1:0]    len_c;
  logic [7:0]                      end_sum;
  logic [rof_pkg::FILL_W-1:0]      addr_sum;
  logic [7:0]                      byte_v;
  logic                            at_end;
  logic                            empty_rule;
  logic [RW+rof_pkg::FAILED_W-1:0] r_ext;
  logic [RW+rof_pkg::FAILED_W-1:0] none_ext;

  assign len_c = (rule_i.length > rof_pkg::LENGTH_W'(rof_pkg::FIELD_BYTES))
               ? rof_pkg::LENGTH_W'(rof_pkg::FIELD_BYTES) : rule_i.length;
  assign end_sum  = {2'b00, rule_i.offset} + {4'b0000, len_c};
  assign addr_sum = {1'b0, off_q} + {3'b000, k_q};
  assign at_end   = (r_q == RW'(MAX_RULES));
  assign empty_rule = (rule_i.offset == '0) && (rule_i.length == '0) &&
                      (rule_i.value == '0);
  // Bytes beyond what this packet filled read as zero.
  assign byte_v   = (addr_q < fill_q) ? rd_data_i : 8'h00;

  // The failing index is reported in four bits, whatever the table depth.
  assign r_ext    = {{rof_pkg::FAILED_W{1'b0}}, r_q};
  assign none_ext = {{rof_pkg::FAILED_W{1'b0}}, RW'(MAX_RULES)};

  always_comb begin
    state_d   = state_q;
    r_d       = r_q;
    fill_d    = fill_q;
    off_d     = off_q;
    len_d     = len_q;
    k_d       = k_q;
    want_d    = want_q;
    seen_d    = seen_q;
    addr_d    = addr_q;
    verdict_d = verdict_q;
    done_o    = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (job_i.start) begin
          fill_d  = job_i.fill;
          r_d     = '0;
          state_d = ST_RULE;
        end
      end
      ST_RULE: begin
        if (at_end || empty_rule) begin
          verdict_d = '{accept: 1'b1, failed_rule: none_ext[rof_pkg::FAILED_W-1:0]};
          state_d   = ST_DONE;
        end else if (end_sum > 8'(WINDOW_BYTES)) begin
          verdict_d = '{accept: 1'b0, failed_rule: r_ext[rof_pkg::FAILED_W-1:0]};
          state_d   = ST_DONE;
        end else if (len_c == '0) begin
          r_d = r_q + RW'(1);
        end else begin
          off_d   = rule_i.offset;
          len_d   = len_c;
          want_d  = rule_i.value & rof_pkg::field_mask(len_c);
          k_d     = '0;
          seen_d  = '0;
          state_d = ST_READ;
        end
      end
      ST_READ: begin
        addr_d  = addr_sum;
        state_d = ST_DATA;
      end
      ST_DATA: begin
        seen_d  = {seen_q[rof_pkg::VALUE_W-9:0], byte_v};
        k_d     = k_q + rof_pkg::LENGTH_W'(1);
        state_d = (k_q + rof_pkg::LENGTH_W'(1) == len_q) ? ST_CHECK : ST_READ;
      end
      ST_CHECK: begin
        if (seen_q == want_q) begin
          r_d     = r_q + RW'(1);
          state_d = ST_RULE;
        end else begin
          verdict_d = '{accept: 1'b0, failed_rule: r_ext[rof_pkg::FAILED_W-1:0]};
          state_d   = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!full_i) begin
          done_o  = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      r_q     <= '0;
    end else begin
      state_q <= state_d;
      r_q     <= r_d;
    end
  end

  always_ff @(posedge clk_i) begin
    fill_q    <= fill_d;
    off_q     <= off_d;
    len_q     <= len_d;
    k_q       <= k_d;
    want_q    <= want_d;
    seen_q    <= seen_d;
    addr_q    <= addr_d;
    verdict_q <= verdict_d;
  end

  assign rule_idx_o = r_q[RIW-1:0];
  assign rd_addr_o  = addr_sum[AW-1:0];
  assign push_o     = done_o;
  assign verdict_o  = verdict_q;

endmodule

`default_nettype wire

### rtl/rof_fifo.sv
// Two-entry queue of verdicts between the rule walker and the output port.
`default_nettype none

module rof_fifo (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              push_i,
  input  wire rof_pkg::verdict_t data_i,
  output logic                   full_o,
  output logic                   valid_o,
  input  wire logic              stall_i,
  output rof_pkg::verdict_t      data_o
);

  rof_pkg::verdict_t entry_q [2];
  logic              wr_ptr_q;
  logic              rd_ptr_q;
  logic [1:0]        count_q;
  logic              pop;

  assign valid_o = (count_q != 2'd0);
  assign full_o  = (count_q == 2'd2);
  assign pop     = valid_o & ~stall_i;
  assign data_o  = entry_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      if (push_i && !pop) begin
        count_q <= count_q + 2'd1;
      end else if (pop && !push_i) begin
        count_q <= count_q - 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

`default_nettype wire

### rtl/packet_offset_rule_filter_core.sv
// Top level of the offset/value packet filter.
// Each input word is either a rule write or one packet byte; words other than the
// last byte of a packet do not stall the intake. The last byte starts a walk of the
// rule table in index order, stopping at the end of the table, the first all-zero
// entry or the first failing rule; the intake stalls until that packet's verdict has
// been placed in a two-entry output queue. For each rule the walk reads the table
// entry, then reads and shifts in each compared byte in turn, since the capture
// window is a single-read-port memory read a byte at a time, and then compares.
// Handing the packet to the walker goes through a register, so the intake stays
// stalled for the walk and the hand-off, and longer while the output queue is full.
// The window is not cleared between packets; bytes a packet did not fill read zero.
`default_nettype none

module packet_offset_rule_filter_core #(
  parameter int unsigned WINDOW_BYTES = 56,
  parameter int unsigned MAX_RULES    = 10
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              in_valid_i,
  output logic                                   in_stall_o,
  input  wire logic                              cmd_i,
  input  wire logic [rof_pkg::INDEX_W-1:0]       rule_index_i,
  input  wire logic [rof_pkg::OFFSET_W-1:0]      rule_offset_i,
  input  wire logic [rof_pkg::LENGTH_W-1:0]      rule_length_i,
  input  wire logic [rof_pkg::VALUE_W-1:0]       rule_value_i,
  input  wire logic [7:0]                        data_byte_i,
  input  wire logic                              last_byte_i,
  output logic                                   out_valid_o,
  input  wire logic                              out_stall_i,
  output logic                                   accept_o,
  output logic [rof_pkg::FAILED_W-1:0]           failed_rule_o
);

  localparam int unsigned AW  = $clog2(WINDOW_BYTES);
  localparam int unsigned RIW = (MAX_RULES > 1) ? $clog2(MAX_RULES) : 1;

  rof_pkg::job_t     job;
  rof_pkg::rule_t    rule;
  rof_pkg::verdict_t verdict;
  rof_pkg::verdict_t out_verdict;
  logic              done;
  logic [RIW-1:0]    rule_idx;
  logic [AW-1:0]     rd_addr;
  logic [7:0]        rd_data;
  logic              push;
  logic              full;

  rof_front #(
    .WINDOW_BYTES (WINDOW_BYTES),
    .MAX_RULES    (MAX_RULES)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .cmd_i         (cmd_i),
    .rule_index_i  (rule_index_i),
    .rule_offset_i (rule_offset_i),
    .rule_length_i (rule_length_i),
    .rule_value_i  (rule_value_i),
    .data_byte_i   (data_byte_i),
    .last_byte_i   (last_byte_i),
    .job_o         (job),
    .done_i        (done),
    .rule_idx_i    (rule_idx),
    .rule_o        (rule),
    .rd_addr_i     (rd_addr),
    .rd_data_o     (rd_data)
  );

  rof_back #(
    .WINDOW_BYTES (WINDOW_BYTES),
    .MAX_RULES    (MAX_RULES)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .job_i      (job),
    .done_o     (done),
    .rule_idx_o (rule_idx),
    .rule_i     (rule),
    .rd_addr_o  (rd_addr),
    .rd_data_i  (rd_data),
    .push_o     (push),
    .verdict_o  (verdict),
    .full_i     (full)
  );

  rof_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (verdict),
    .full_o  (full),
    .valid_o (out_valid_o),
    .stall_i (out_stall_i),
    .data_o  (out_verdict)
  );

  assign accept_o      = out_verdict.accept;
  assign failed_rule_o = out_verdict.failed_rule;

endmodule

`default_nettype wire
